FILE: src/pfx_pkg.sv
`default_nettype none

package pfx_pkg;

	localparam int POS_WIDTH  = 11;
	localparam int SIZE_WIDTH = 11;
	localparam int OUT_WIDTH  = 32;
	localparam int EXT_WIDTH  = 64;

	localparam logic [SIZE_WIDTH-1:0] SIZE_RESET = 11'd1024;
	localparam logic [EXT_WIDTH-1:0]  OUT_MAX    = 64'h0000_0000_FFFF_FFFF;

	localparam logic CMD_INCREMENT = 1'b0;
	localparam logic CMD_QUERY     = 1'b1;

	typedef struct packed {
		logic start;
		logic issue;
		logic clr_step;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic walk_more;
		logic clr_last;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

FILE: src/pfx_ram.sv
`default_nettype none

module pfx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1025,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

FILE: src/pfx_datapath.sv
`default_nettype none

module pfx_datapath #(
	parameter int MAX_POSITIONS = 1024,
	parameter int COUNT_WIDTH = 32,
	localparam int AW = $clog2(MAX_POSITIONS + 1),
	localparam int PW = ((AW > pfx_pkg::POS_WIDTH) ? AW : pfx_pkg::POS_WIDTH) + 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pfx_pkg::ctl_cmd_t                ctl,
	output pfx_pkg::dp_status_t              status,
	input  logic                             cfg_write,
	input  logic [pfx_pkg::SIZE_WIDTH-1:0]   cfg_data,
	input  logic                             command,
	input  logic [pfx_pkg::POS_WIDTH-1:0]    position,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [pfx_pkg::OUT_WIDTH-1:0]    prefix_count,
	output logic                             bad_position,
	output logic                             wr_en,
	output logic [AW-1:0]                    wr_addr,
	output logic [COUNT_WIDTH-1:0]           wr_data,
	output logic                             rd_en,
	output logic [AW-1:0]                    rd_addr,
	input  logic [COUNT_WIDTH-1:0]           rd_data
);

	import pfx_pkg::*;

	logic [SIZE_WIDTH-1:0]  size_q;
	logic [AW-1:0]          clr_q;
	logic [PW-1:0]          ptr_q;
	logic [PW-1:0]          eff_q;
	logic                   cmd_q;
	logic                   bad_q;
	logic [COUNT_WIDTH-1:0] acc_q;
	logic [AW-1:0]          addr_s1;
	logic                   vld_s1;
	logic                   result_valid_q;
	logic [OUT_WIDTH-1:0]   prefix_count_q;
	logic                   bad_position_q;

	logic [PW-1:0]          size_ext;
	logic [PW-1:0]          max_pos;
	logic [PW-1:0]          eff_now;
	logic [PW-1:0]          pos_ext;
	logic                   pos_bad;
	logic [PW-1:0]          low_bit;
	logic [PW-1:0]          ptr_next;
	logic [COUNT_WIDTH:0]   acc_wide;
	logic [COUNT_WIDTH-1:0] acc_sat;
	logic [COUNT_WIDTH-1:0] cell_inc;
	logic [EXT_WIDTH-1:0]   acc_ext;
	logic [OUT_WIDTH-1:0]   count_out;

	assign size_ext = PW'(size_q);
	assign max_pos  = PW'(MAX_POSITIONS);
	assign eff_now  = (size_ext > max_pos) ? max_pos : size_ext;
	assign pos_ext  = PW'(position);
	assign pos_bad  = (pos_ext == '0) || (pos_ext > eff_now);

	assign low_bit  = ptr_q & (~ptr_q + PW'(1));
	assign ptr_next = (cmd_q == CMD_INCREMENT) ? ptr_q + low_bit : ptr_q & (ptr_q - PW'(1));

	assign acc_wide = {1'b0, acc_q} + {1'b0, rd_data};
	assign acc_sat  = acc_wide[COUNT_WIDTH] ? '1 : acc_wide[COUNT_WIDTH-1:0];
	assign cell_inc = (&rd_data) ? rd_data : rd_data + COUNT_WIDTH'(1);

	assign acc_ext   = EXT_WIDTH'(acc_q);
	assign count_out = (acc_ext > OUT_MAX) ? '1 : acc_ext[OUT_WIDTH-1:0];

	assign status.walk_more = (ptr_q != '0) && ((cmd_q == CMD_QUERY) || (ptr_q <= eff_q));
	assign status.clr_last  = (clr_q == AW'(MAX_POSITIONS));
	assign status.out_free  = !result_valid_q || !result_stall;

	assign rd_en   = ctl.issue;
	assign rd_addr = ptr_q[AW-1:0];

	always_comb begin
		if (ctl.clr_step) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else begin
			wr_en   = vld_s1 && (cmd_q == CMD_INCREMENT);
			wr_addr = addr_s1;
			wr_data = cell_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q         <= SIZE_RESET;
			clr_q          <= '0;
			vld_s1         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				size_q <= cfg_data;
			end
			if (ctl.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			vld_s1 <= ctl.issue;
			if (ctl.out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			cmd_q <= command;
			eff_q <= eff_now;
			acc_q <= '0;
			if (command == CMD_INCREMENT) begin
				bad_q <= pos_bad;
				ptr_q <= pos_bad ? '0 : pos_ext;
			end else begin
				bad_q <= 1'b0;
				ptr_q <= (pos_ext > eff_now) ? eff_now : pos_ext;
			end
		end else begin
			if (ctl.issue) begin
				ptr_q <= ptr_next;
			end
			if (vld_s1 && (cmd_q == CMD_QUERY)) begin
				acc_q <= acc_sat;
			end
		end
		if (ctl.issue) begin
			addr_s1 <= ptr_q[AW-1:0];
		end
		if (ctl.out_load) begin
			prefix_count_q <= count_out;
			bad_position_q <= bad_q;
		end
	end

	assign result_valid = result_valid_q;
	assign prefix_count = prefix_count_q;
	assign bad_position = bad_position_q;

endmodule

`default_nettype wire

FILE: src/pfx_controller.sv
`default_nettype none

module pfx_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  pfx_pkg::dp_status_t status,
	output pfx_pkg::ctl_cmd_t   ctl
);

	import pfx_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN
	} state_t;

	state_t state_q;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_CLEAR: ctl.clr_step = 1'b1;
			ST_IDLE:  ctl.start    = item_valid;
			ST_WALK:  ctl.issue    = status.walk_more;
			ST_DRAIN: ctl.out_load = status.out_free;
			default:  ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (status.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (!status.walk_more) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/prefix_count_tree.sv
// An item visits L tree cells (L <= log2(MAX_POSITIONS) + 1, 11 at 1024 positions).
// The walk reads the cells one at a time on the single read port of the cell memory, then
// finishes the last cell, and the result register is loaded once the output is free.
// The next word is taken after the result is loaded, and a stalled result holds the input
// off longer.
// Reset: size_q returns to 1024 and a clearing pass zeroes all MAX_POSITIONS + 1 cells,
// one per cycle, with item_stall high; configuration writes are taken meanwhile.
`default_nettype none

module prefix_count_tree #(
	parameter int MAX_POSITIONS = 1024,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [pfx_pkg::SIZE_WIDTH-1:0] cfg_data,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic                           command,
	input  logic [pfx_pkg::POS_WIDTH-1:0]  position,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [pfx_pkg::OUT_WIDTH-1:0]  prefix_count,
	output logic                           bad_position
);

	import pfx_pkg::*;

	localparam int AW = $clog2(MAX_POSITIONS + 1);

	ctl_cmd_t               ctl;
	dp_status_t             status;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [COUNT_WIDTH-1:0] wr_data;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic [COUNT_WIDTH-1:0] rd_data;

	pfx_controller u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.ctl        (ctl)
	);

	pfx_datapath #(
		.MAX_POSITIONS (MAX_POSITIONS),
		.COUNT_WIDTH   (COUNT_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.status       (status),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.command      (command),
		.position     (position),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.prefix_count (prefix_count),
		.bad_position (bad_position),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data)
	);

	pfx_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (MAX_POSITIONS + 1)
	) u_cells (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// A cell is never read in the same cycle that it is written.
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("cell read collides with write");

	// An accepted word keeps the input stalled until its result is loaded.
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("input not stalled after accept");

	// A rejected increment never reports a count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && bad_position) |-> (prefix_count == '0))
		else $error("rejected increment carries a count");

	// No memory read is issued while the clearing pass runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr_step |-> (!rd_en && !ctl.start))
		else $error("access during clearing pass");

endmodule

`default_nettype wire

FILE: dv/prefix_count_tree_check.sv
`default_nettype none

module prefix_count_tree_check #(
	parameter int MAX_POSITIONS = 1024,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [pfx_pkg::SIZE_WIDTH-1:0] cfg_data,
	input  logic                           item_valid,
	input  logic                           item_stall,
	input  logic                           command,
	input  logic [pfx_pkg::POS_WIDTH-1:0]  position,
	input  logic                           result_valid,
	input  logic                           result_stall,
	input  logic [pfx_pkg::OUT_WIDTH-1:0]  prefix_count,
	input  logic                           bad_position,
	output int unsigned                    mismatches,
	output int unsigned                    words_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import pfx_pkg::*;

	localparam logic [64:0] CELL_MAX = (65'd1 << COUNT_WIDTH) - 65'd1;

	typedef struct packed {
		logic [OUT_WIDTH-1:0] count;
		logic                 bad;
	} tally_t;

	logic [COUNT_WIDTH-1:0] cell_copy [0:MAX_POSITIONS];
	logic [SIZE_WIDTH-1:0]  size_copy;
	tally_t                 tally_due_q [$];
	int unsigned            err_total;
	int unsigned            seen_total;

	function automatic tally_t walk_tree(input logic cmd, input logic [POS_WIDTH-1:0] pos);
		tally_t      t;
		int unsigned p;
		int unsigned lim;
		logic [64:0] sum;
		lim = (size_copy > MAX_POSITIONS) ? MAX_POSITIONS : size_copy;
		p = pos;
		sum = '0;
		t.count = '0;
		t.bad = 1'b0;
		if (cmd == CMD_INCREMENT) begin
			if (p == 0 || p > lim) begin
				t.bad = 1'b1;
			end else begin
				while (p != 0 && p <= lim) begin
					if (cell_copy[p] != CELL_MAX[COUNT_WIDTH-1:0])
						cell_copy[p] = cell_copy[p] + 1'b1;
					p = p + (p & (~p + 1));
				end
			end
		end else begin
			if (p > lim)
				p = lim;
			while (p != 0) begin
				sum = sum + cell_copy[p];
				if (sum > CELL_MAX)
					sum = CELL_MAX;
				p = p - (p & (~p + 1));
			end
			if (sum > {1'b0, OUT_MAX})
				sum = {1'b0, OUT_MAX};
			t.count = sum[OUT_WIDTH-1:0];
		end
		return t;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tally_t want;
		if (!arst_n) begin
			for (int i = 0; i <= MAX_POSITIONS; i++)
				cell_copy[i] = '0;
			size_copy = SIZE_RESET;
			tally_due_q.delete();
			err_total = 0;
			seen_total = 0;
			mismatches <= 0;
			words_checked <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				seen_total++;
				if (tally_due_q.size() == 0) begin
					err_total++;
					$display("%0t: result word with nothing outstanding: %s %0d %s %0b",
						$time, "prefix_count", prefix_count,
						"bad_position", bad_position);
				end else begin
					want = tally_due_q.pop_front();
					if (want.count !== prefix_count) begin
						$display("%0t: prefix_count expected %0d actual %0d",
							$time, want.count, prefix_count);
						err_total++;
					end
					if (want.bad !== bad_position) begin
						$display("%0t: bad_position expected %0b actual %0b",
							$time, want.bad, bad_position);
						err_total++;
					end
				end
			end
			if (item_valid && !item_stall)
				tally_due_q.push_back(walk_tree(command, position));
			if (cfg_write)
				size_copy = cfg_data;
			mismatches <= err_total;
			words_checked <= seen_total;
		end
	end

endmodule

`default_nettype wire

FILE: dv/prefix_count_tree_test.sv
`default_nettype none

module prefix_count_tree_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pfx_pkg::*;

	localparam int          MAX_POS     = 1024;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int          PHASES      = 7;
	localparam int          PHASE_WORDS = 62;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [SIZE_WIDTH-1:0] cfg_data = '0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	logic                  command = CMD_INCREMENT;
	logic [POS_WIDTH-1:0]  position = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [OUT_WIDTH-1:0]  prefix_count;
	logic                  bad_position;

	int unsigned mismatches;
	int unsigned words_checked;
	int unsigned words_sent = 0;
	int unsigned increments_sent = 0;
	int unsigned queries_sent = 0;
	int unsigned settings_used = 0;
	int unsigned cycles = 0;
	int unsigned size_now = SIZE_RESET;
	logic        calm = 1'b0;

	always begin
		#2ns clk = 1'b1;
		#2ns clk = 1'b0;
	end

	prefix_count_tree #(
		.MAX_POSITIONS(MAX_POS),
		.COUNT_WIDTH(32)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.command(command),
		.position(position),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.prefix_count(prefix_count),
		.bad_position(bad_position)
	);

	prefix_count_tree_check #(
		.MAX_POSITIONS(MAX_POS),
		.COUNT_WIDTH(32)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.command(command),
		.position(position),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.prefix_count(prefix_count),
		.bad_position(bad_position),
		.mismatches(mismatches),
		.words_checked(words_checked)
	);

	always @(posedge clk) begin
		result_stall <= !calm && ($urandom_range(99) < 13);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("prefix_count_tree test failed");
			$finish;
		end
	end

	task automatic send_word(input logic cmd, input int unsigned pos);
		while (!calm && $urandom_range(99) < 13) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		command <= cmd;
		position <= pos[POS_WIDTH-1:0];
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		words_sent++;
		if (cmd == CMD_INCREMENT)
			increments_sent++;
		else
			queries_sent++;
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		while (words_checked != words_sent)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_size(input int unsigned value);
		drain_results();
		cfg_write <= 1'b1;
		cfg_data <= value[SIZE_WIDTH-1:0];
		@(posedge clk);
		cfg_write <= 1'b0;
		size_now = value;
		settings_used++;
	endtask

	initial begin
		int unsigned phase_size [PHASES];
		int unsigned lim;
		int unsigned pos;
		int          pick;
		logic        cmd;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(CMD_QUERY, 0);
		send_word(CMD_QUERY, 1024);
		send_word(CMD_INCREMENT, 0);
		send_word(CMD_INCREMENT, 1025);
		send_word(CMD_INCREMENT, 2047);
		send_word(CMD_INCREMENT, 1);
		send_word(CMD_INCREMENT, 1024);
		send_word(CMD_INCREMENT, 1023);
		send_word(CMD_INCREMENT, 512);
		send_word(CMD_INCREMENT, 513);
		send_word(CMD_QUERY, 1);
		send_word(CMD_QUERY, 512);
		send_word(CMD_QUERY, 1023);
		send_word(CMD_QUERY, 1024);
		send_word(CMD_QUERY, 2047);

		set_size(0);
		send_word(CMD_INCREMENT, 1);
		send_word(CMD_QUERY, 5);
		send_word(CMD_QUERY, 0);
		set_size(1);
		send_word(CMD_INCREMENT, 1);
		send_word(CMD_INCREMENT, 2);
		send_word(CMD_QUERY, 2047);
		set_size(2047);
		send_word(CMD_INCREMENT, 1024);
		send_word(CMD_QUERY, 2047);
		send_word(CMD_QUERY, 700);

		phase_size[0] = 1024;
		phase_size[1] = 1;
		phase_size[2] = $urandom_range(1023, 2);
		phase_size[3] = 1024;
		phase_size[4] = $urandom_range(2046, 1025);
		phase_size[5] = 3;
		phase_size[6] = 2047;

		for (int ph = 0; ph < PHASES; ph++) begin
			set_size(phase_size[ph]);
			calm <= (ph == 3);
			lim = (size_now > MAX_POS) ? MAX_POS : size_now;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				cmd = ($urandom_range(99) < 55) ? CMD_INCREMENT : CMD_QUERY;
				pick = $urandom_range(99);
				if (pick < 80)
					pos = $urandom_range(lim, 1);
				else if (pick < 85)
					pos = 0;
				else if (pick < 90)
					pos = lim + 1;
				else
					pos = $urandom_range(2047, 0);
				send_word(cmd, pos);
			end
		end
		calm <= 1'b0;

		drain_results();
		repeat (30) @(posedge clk);
		$display("Sent %0d increments and %0d queries across %0d size settings",
			increments_sent, queries_sent, settings_used);
		$display("(0, 1, 3, 1024, 2047 and random).");
		$display("Compared %0d result words, %0d mismatches.", words_checked, mismatches);
		if (mismatches == 0 && words_checked == words_sent) begin
			$display("prefix_count_tree test passed");
		end else begin
			$display("prefix_count_tree test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
src/pfx_pkg.sv
src/pfx_ram.sv
src/pfx_datapath.sv
src/pfx_controller.sv
src/prefix_count_tree.sv
dv/prefix_count_tree_check.sv
dv/prefix_count_tree_test.sv
